// ===== rtl/ecal_pkg.sv =====
// Shared constants, pipeline types and the month table for the epoch seconds to
// calendar unit. It depends on nothing and is compiled first.
package ecal_pkg;

  // Register stages from the input beat to the output register.
  localparam int NUM_STG = 10;

  // Supported span: 0001-01-01 00:00:00 to 9999-12-31 23:59:59.
  localparam logic signed [39:0] FIRST_SEC = -40'sd62135596800;
  localparam logic signed [39:0] LAST_SEC  = 40'sd253402300799;

  // 86400 = 128 * 675. The quotient by 675 is ceil(2^41 / 675) times x, shifted by 41.
  localparam logic [31:0] DAY_RECIP = 32'd3257812231;
  localparam logic [9:0]  DAY_ODD   = 10'd675;

  // Days from 0000-03-01 to 0001-01-01.
  localparam logic [21:0] MARCH_OFS = 22'd306;

  // Days in a 400 year era, and ceil(2^39 / 146097).
  localparam logic [17:0] ERA_DAYS  = 18'd146097;
  localparam logic [21:0] ERA_RECIP = 22'd3762951;

  // 3600 = 16 * 225. The quotient by 225 is ceil(2^20 / 225) times x, shifted by 20.
  localparam logic [12:0] HOUR_RECIP   = 13'd4661;
  localparam logic [11:0] SEC_PER_HOUR = 12'd3600;

  // ceil(2^25 / 7) for the weekday.
  localparam logic [22:0] WEEK_RECIP    = 23'd4793491;
  localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

  // ceil(2^27 / 365); shifted by 29 instead it also divides by 1460.
  localparam logic [18:0] YEAR_RECIP    = 19'd367720;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

  // 60 = 4 * 15. The quotient by 15 is ceil(2^14 / 15) times x, shifted by 14.
  localparam logic [10:0] MIN_RECIP   = 11'd1093;
  localparam logic [5:0]  SEC_PER_MIN = 6'd60;

  // Day counts at which a new century starts inside an era.
  localparam logic [17:0] CENT_1 = 18'd36524;
  localparam logic [17:0] CENT_2 = 18'd73048;
  localparam logic [17:0] CENT_3 = 18'd109572;
  localparam logic [17:0] CENT_4 = 18'd146096;

  // Offsets of the month start in a March-based year.
  localparam logic [3:0] MP_JAN       = 4'd10;
  localparam logic [8:0] JAN_OFS      = 9'd306;
  localparam logic [8:0] MAR_YDAY     = 9'd59;

  // Stage 4 result: the day split into era, day of era and time of day.
  typedef struct packed {
    logic        err;
    logic [4:0]  era;
    logic [17:0] doe;
    logic [4:0]  hour;
    logic [11:0] remh;
    logic [2:0]  wd;
  } ecal_day_t;

  // Final calendar fields.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  dom;
    logic [8:0]  yday;
    logic [2:0]  wd;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        err;
  } ecal_cal_t;

  // Per-stage load enables of the pipeline.
  typedef struct packed {
    logic [NUM_STG-1:0] adv;
  } ecal_ctrl_t;

  // First day of each month counted from March 1st, March being index 0.
  function automatic logic [8:0] mar_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ecal_civil.sv =====
// Back half of the pipeline: day of era to year, month, day and day of year, plus
// minute and second. Depends on ecal_pkg; stage enables come from the top level.
module ecal_civil
  import ecal_pkg::*;
(
  input  logic       clk,
  input  ecal_ctrl_t ctrl,
  input  ecal_day_t  day_i,
  output ecal_cal_t  cal_o
);

  // Stage 5: years of 1460 days and centuries, minute product.
  ecal_day_t   d5_r;
  logic [35:0] ap5_r, ap5_nxt;
  logic [2:0]  b5_r, b5_nxt;
  logic        c5_r, c5_nxt;
  logic [19:0] pm5_r, pm5_nxt;

  // Stage 6: day count with leap days taken out, minute and second.
  ecal_day_t   d6_r;
  logic [17:0] n6_r, n6_nxt;
  logic [5:0]  min6_r, min6_nxt;
  logic [5:0]  sec6_r, sec6_nxt;
  logic [6:0]  a6;
  logic [11:0] sec6_full;

  // Stage 7: year of era product.
  ecal_day_t   d7_r;
  logic [35:0] yp7_r, yp7_nxt;
  logic [5:0]  min7_r, sec7_r;

  // Stage 8: year of era and day of March-based year.
  ecal_day_t   d8_r;
  logic [8:0]  yoe8_r, yoe8_nxt;
  logic [8:0]  doy8_r, doy8_nxt;
  logic [5:0]  min8_r, sec8_r;
  logic [1:0]  yc8;
  logic [17:0] base8;
  logic [17:0] doy8_full;

  // Stage 9: output register.
  ecal_cal_t   cal9_r, cal9_nxt;
  logic [3:0]  mp9;
  logic        jan_feb9;
  logic        leap9;
  logic [8:0]  dom9_full;

  always_comb begin
    ap5_nxt = 36'(day_i.doe) * 36'(YEAR_RECIP);
    b5_nxt  = 3'(day_i.doe >= CENT_1) + 3'(day_i.doe >= CENT_2)
            + 3'(day_i.doe >= CENT_3) + 3'(day_i.doe >= CENT_4);
    c5_nxt  = (day_i.doe == CENT_4);
    pm5_nxt = 20'(day_i.remh[11:2]) * 20'(MIN_RECIP);
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[5]) begin
      d5_r  <= day_i;
      ap5_r <= ap5_nxt;
      b5_r  <= b5_nxt;
      c5_r  <= c5_nxt;
      pm5_r <= pm5_nxt;
    end
  end

  always_comb begin
    a6        = ap5_r[35:29];
    n6_nxt    = d5_r.doe - 18'(a6) + 18'(b5_r) - 18'(c5_r);
    min6_nxt  = pm5_r[19:14];
    sec6_full = d5_r.remh - 12'(min6_nxt) * 12'(SEC_PER_MIN);
    sec6_nxt  = sec6_full[5:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[6]) begin
      d6_r   <= d5_r;
      n6_r   <= n6_nxt;
      min6_r <= min6_nxt;
      sec6_r <= sec6_nxt;
    end
  end

  assign yp7_nxt = 36'(n6_r) * 36'(YEAR_RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.adv[7]) begin
      d7_r   <= d6_r;
      yp7_r  <= yp7_nxt;
      min7_r <= min6_r;
      sec7_r <= sec6_r;
    end
  end

  always_comb begin
    yoe8_nxt  = yp7_r[35:27];
    yc8       = 2'(yoe8_nxt >= 9'd100) + 2'(yoe8_nxt >= 9'd200) + 2'(yoe8_nxt >= 9'd300);
    base8     = 18'(yoe8_nxt) * 18'(DAYS_PER_YEAR) + 18'(yoe8_nxt[8:2]) - 18'(yc8);
    doy8_full = d7_r.doe - base8;
    doy8_nxt  = doy8_full[8:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[8]) begin
      d8_r   <= d7_r;
      yoe8_r <= yoe8_nxt;
      doy8_r <= doy8_nxt;
      min8_r <= min7_r;
      sec8_r <= sec7_r;
    end
  end

  // Month from eleven parallel compares against the month starts.
  always_comb begin
    mp9 = 4'd0;
    for (int i = 1; i < 12; i++) begin
      mp9 = mp9 + 4'(doy8_r >= mar_start(4'(i)));
    end
    jan_feb9  = (mp9 >= MP_JAN);
    leap9     = (yoe8_r[1:0] == 2'd0) && (yoe8_r != 9'd100) && (yoe8_r != 9'd200)
             && (yoe8_r != 9'd300);
    dom9_full = doy8_r - mar_start(mp9) + 9'd1;

    cal9_nxt.year   = 14'(d8_r.era) * 14'd400 + 14'(yoe8_r) + 14'(jan_feb9);
    cal9_nxt.month  = jan_feb9 ? (mp9 - 4'd9) : (mp9 + 4'd3);
    cal9_nxt.dom    = dom9_full[4:0];
    cal9_nxt.yday   = jan_feb9 ? (doy8_r - JAN_OFS) : (doy8_r + MAR_YDAY + 9'(leap9));
    cal9_nxt.wd     = d8_r.wd;
    cal9_nxt.hour   = d8_r.hour;
    cal9_nxt.minute = min8_r;
    cal9_nxt.second = sec8_r;
    cal9_nxt.err    = d8_r.err;
    if (d8_r.err) begin
      cal9_nxt     = '0;
      cal9_nxt.err = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[9]) begin
      cal9_r <= cal9_nxt;
    end
  end

  assign cal_o = cal9_r;

endmodule

// ===== rtl/epoch_seconds_to_calendar_unit.sv =====
// Top level of the epoch seconds to calendar unit: handshake, pipeline control
// and the front half of the datapath. Depends on ecal_pkg and ecal_civil.
//
// The unit turns a signed 39-bit count of seconds since 1970-01-01 00:00:00 UTC
// into proleptic Gregorian year, month, day of month, day of year (0-based),
// weekday (0 is Sunday), hour, minute and second. Inputs before year 1 or after
// year 9999 give a beat with range_error set and every other field zero. The
// datapath is a ten-stage pipeline with a valid bit per stage: one beat is
// accepted every clock cycle while in_stall is low. The depth comes from the
// chain of reciprocal multiplications (days, eras, years of era, hours,
// minutes, weekday), each followed by a register. When the output is
// stalled, stages holding a beat freeze, while empty stages further up keep
// filling, so in_stall only rises once every stage holds a beat. No state
// survives between beats, so reset only clears the valid bits.
module epoch_seconds_to_calendar_unit
  import ecal_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [38:0] in_epoch_seconds,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [13:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day_of_month,
  output logic [8:0]         out_day_of_year,
  output logic [2:0]         out_weekday,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second,
  output logic               out_range_error
);

  logic [NUM_STG-1:0] v_r, v_nxt;
  ecal_ctrl_t         ctrl;
  ecal_cal_t          cal;

  // Stage 0: offset to seconds since year 1 and range check.
  logic signed [39:0] s0_ext;
  logic [39:0]        u0_sum;
  logic [38:0]        u0_r;
  logic               e0_r, e0_nxt;

  // Stage 1: day quotient product.
  logic [63:0]        p1_r, p1_nxt;
  logic [31:0]        x1_r;
  logic [6:0]         lo1_r;
  logic               e1_r;

  // Stage 2: day number and time of day.
  logic [21:0]        d2_r, d2_nxt;
  logic [16:0]        tod2_r, tod2_nxt;
  logic [31:0]        rem2_full;
  logic               e2_r;

  // Stage 3: era, hour and weekday products.
  logic [21:0]        z3_r, z3_nxt;
  logic [21:0]        w3_r, w3_nxt;
  logic [43:0]        pe3_r, pe3_nxt;
  logic [24:0]        ph3_r, ph3_nxt;
  logic [44:0]        pw3_r, pw3_nxt;
  logic [16:0]        tod3_r;
  logic               e3_r;

  // Stage 4: era, day of era, hour, seconds into the hour, weekday.
  ecal_day_t          day4_r, day4_nxt;
  logic [21:0]        doe4_full;
  logic [16:0]        remh4_full;
  logic [19:0]        wq4;
  logic [21:0]        wd4_full;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    ctrl.adv[NUM_STG-1] = !v_r[NUM_STG-1] || !out_stall;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      ctrl.adv[k] = !v_r[k] || ctrl.adv[k+1];
    end
  end

  always_comb begin
    v_nxt[0] = ctrl.adv[0] ? in_valid : v_r[0];
    for (int k = 1; k < NUM_STG; k++) begin
      v_nxt[k] = ctrl.adv[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !ctrl.adv[0];
  assign out_valid = v_r[NUM_STG-1];

  // Stage 0.
  always_comb begin
    s0_ext = 40'(in_epoch_seconds);
    u0_sum = 40'(s0_ext - FIRST_SEC);
    e0_nxt = (s0_ext < FIRST_SEC) || (s0_ext > LAST_SEC);
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[0]) begin
      u0_r <= u0_sum[38:0];
      e0_r <= e0_nxt;
    end
  end

  // Stage 1: the low seven bits of 86400 are a plain shift.
  assign p1_nxt = 64'(u0_r[38:7]) * 64'(DAY_RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.adv[1]) begin
      p1_r  <= p1_nxt;
      x1_r  <= u0_r[38:7];
      lo1_r <= u0_r[6:0];
      e1_r  <= e0_r;
    end
  end

  // Stage 2.
  always_comb begin
    d2_nxt    = p1_r[62:41];
    rem2_full = x1_r - 32'(d2_nxt) * 32'(DAY_ODD);
    tod2_nxt  = {rem2_full[9:0], lo1_r};
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[2]) begin
      d2_r   <= d2_nxt;
      tod2_r <= tod2_nxt;
      e2_r   <= e1_r;
    end
  end

  // Stage 3: day 0 is a Monday, hence the weekday of day d is (d + 1) mod 7.
  always_comb begin
    z3_nxt  = d2_r + MARCH_OFS;
    w3_nxt  = d2_r + 22'd1;
    pe3_nxt = 44'(z3_nxt) * 44'(ERA_RECIP);
    ph3_nxt = 25'(tod2_r[16:4]) * 25'(HOUR_RECIP);
    pw3_nxt = 45'(w3_nxt) * 45'(WEEK_RECIP);
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[3]) begin
      z3_r   <= z3_nxt;
      w3_r   <= w3_nxt;
      pe3_r  <= pe3_nxt;
      ph3_r  <= ph3_nxt;
      pw3_r  <= pw3_nxt;
      tod3_r <= tod2_r;
      e3_r   <= e2_r;
    end
  end

  // Stage 4.
  always_comb begin
    day4_nxt.err  = e3_r;
    day4_nxt.era  = pe3_r[43:39];
    doe4_full     = z3_r - 22'(day4_nxt.era) * 22'(ERA_DAYS);
    day4_nxt.doe  = doe4_full[17:0];
    day4_nxt.hour = ph3_r[24:20];
    remh4_full    = tod3_r - 17'(day4_nxt.hour) * 17'(SEC_PER_HOUR);
    day4_nxt.remh = remh4_full[11:0];
    wq4           = pw3_r[44:25];
    wd4_full      = w3_r - 22'(wq4) * 22'(DAYS_PER_WEEK);
    day4_nxt.wd   = wd4_full[2:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[4]) begin
      day4_r <= day4_nxt;
    end
  end

  // Stages 5 to 9.
  ecal_civil u_civil (
    .clk   (clk),
    .ctrl  (ctrl),
    .day_i (day4_r),
    .cal_o (cal)
  );

  assign out_year         = cal.year;
  assign out_month        = cal.month;
  assign out_day_of_month = cal.dom;
  assign out_day_of_year  = cal.yday;
  assign out_weekday      = cal.wd;
  assign out_hour         = cal.hour;
  assign out_minute       = cal.minute;
  assign out_second       = cal.second;
  assign out_range_error  = cal.err;

  // An out of range beat carries nothing but its flag.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_range_error |-> (out_year == 14'd0) && (out_month == 4'd0)
      && (out_day_of_month == 5'd0) && (out_day_of_year == 9'd0) && (out_weekday == 3'd0)
      && (out_hour == 5'd0) && (out_minute == 6'd0) && (out_second == 6'd0))
    else $error("range error beat with non-zero fields");

  // A valid date and time always lie in their ranges.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_range_error |-> (out_year != 14'd0) && (out_year <= 14'd9999)
      && (out_month != 4'd0) && (out_month <= 4'd12) && (out_day_of_month != 5'd0)
      && (out_weekday <= 3'd6) && (out_hour <= 5'd23) && (out_minute <= 6'd59)
      && (out_second <= 6'd59) && (out_day_of_year <= 9'd365))
    else $error("calendar field out of range");

  // In January the day of year follows directly from the day of month.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_range_error && (out_month == 4'd1)
      |-> (out_day_of_year == 9'(out_day_of_month) - 9'd1))
    else $error("January day of year mismatch");

  // The input is held off only when every stage holds a beat and the output stalls.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r) && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule
